// File: hw/rtl/stereo_bar_meter_peak_hold_defines.svh
// ----------------------------------------------------------------------------
// stereo bar meter assertion macros
// shared property forms for the checker files of the meter
// ----------------------------------------------------------------------------
`ifndef STEREO_BAR_METER_PEAK_HOLD_DEFINES_SVH
`define STEREO_BAR_METER_PEAK_HOLD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// widths, register codes and shared types of the stereo bar meter
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int LEVEL_MAX  = (1 << LEVEL_BITS) - 1;
  localparam int MAG_BITS   = 17;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_BITS   = 8;
  localparam int HOLD_BITS  = 5;
  localparam int OUT_BITS   = 8;
  localparam int WIDE_BITS  = 16;
  localparam int IDX_BITS   = 2;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [MAG_BITS-1:0]   mag_t;
  typedef logic [CFG_BITS-1:0]   cfg_t;
  typedef logic [HOLD_BITS-1:0]  timer_t;
  typedef logic [IDX_BITS-1:0]   cfg_idx_t;
  typedef logic [WIDE_BITS-1:0]  wide_t;

  // register indexes
  localparam cfg_idx_t CFG_SEGMENT_COUNT = 2'd0;
  localparam cfg_idx_t CFG_RED_THRESHOLD = 2'd1;
  localparam cfg_idx_t CFG_DECAY_FACTOR  = 2'd2;
  localparam cfg_idx_t CFG_HOLD_TICKS    = 2'd3;

  // register reset values
  localparam cfg_t   RST_SEGMENT_COUNT = 8'd6;
  localparam cfg_t   RST_RED_THRESHOLD = 8'd4;
  localparam cfg_t   RST_DECAY_FACTOR  = 8'd230;
  localparam timer_t RST_HOLD_TICKS    = 5'd30;

  typedef struct packed {
    level_t shown;
    level_t peak;
  } chan_state_t;

endpackage

// File: hw/rtl/sbm_quant.sv
// ----------------------------------------------------------------------------
// sbm_quant
// one quantizer lane: magnitude to clamped segment count, registered
// ----------------------------------------------------------------------------
module sbm_quant (
  input  logic            clk,
  input  logic            en,
  input  sbm_pkg::mag_t   mag,
  input  sbm_pkg::cfg_t   seg,
  output sbm_pkg::level_t q
);

  logic [sbm_pkg::MAG_BITS+sbm_pkg::CFG_BITS-1:0] prod;
  sbm_pkg::wide_t raw;
  sbm_pkg::wide_t seg_w;
  sbm_pkg::wide_t lim;
  sbm_pkg::wide_t clamped;

  always_comb begin
    prod  = mag * seg;
    raw   = sbm_pkg::WIDE_BITS'(prod >> sbm_pkg::FRAC_BITS);
    seg_w = sbm_pkg::WIDE_BITS'(seg);
    // tighter of full scale and level range
    lim   = (seg_w > sbm_pkg::WIDE_BITS'(sbm_pkg::LEVEL_MAX)) ?
            sbm_pkg::WIDE_BITS'(sbm_pkg::LEVEL_MAX) : seg_w;
    clamped = (raw > lim) ? lim : raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= sbm_pkg::LEVEL_BITS'(clamped);
    end
  end

endmodule

// File: hw/rtl/sbm_chan.sv
// ----------------------------------------------------------------------------
// sbm_chan
// one channel update: peak hold, shared timer step and bar falloff
// ----------------------------------------------------------------------------
module sbm_chan (
  input  sbm_pkg::level_t     q,
  input  sbm_pkg::chan_state_t cur,
  input  sbm_pkg::timer_t     timer_in,
  input  sbm_pkg::timer_t     hold_ticks,
  input  sbm_pkg::cfg_t       decay_factor,
  output sbm_pkg::chan_state_t nxt,
  output sbm_pkg::timer_t     timer_out
);

  logic [sbm_pkg::LEVEL_BITS+sbm_pkg::CFG_BITS-1:0] decayed;
  sbm_pkg::level_t peak_hit;

  always_comb begin
    if (q > cur.peak) begin
      peak_hit  = q;
      timer_out = hold_ticks;
    end else begin
      peak_hit  = cur.peak;
      timer_out = (timer_in == '0) ? timer_in : timer_in - 1'b1;
    end

    nxt.peak = ((timer_out == '0) && (peak_hit != '0)) ? peak_hit - 1'b1 : peak_hit;

    decayed = cur.shown * decay_factor;
    if (q > cur.shown) begin
      nxt.shown = q;
    end else if (q < cur.shown) begin
      nxt.shown = decayed[sbm_pkg::LEVEL_BITS+sbm_pkg::CFG_BITS-1:sbm_pkg::CFG_BITS];
    end else begin
      nxt.shown = cur.shown;
    end
  end

endmodule

// File: hw/rtl/stereo_bar_meter_peak_hold.sv
// ----------------------------------------------------------------------------
// stereo_bar_meter_peak_hold
// two-bar level meter with shared peak hold timer and red-zone flags
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_ready is high (it drops while a result
// waits behind a stalled output) and returns one result per request. The left
// and right quantizer lanes run side by side (magnitude times segment count,
// clamped) into the quantizer register; then the left and the right channel
// updater run back to back, since the right sees the hold timer as the left
// one left it, and load the output register. That updater chain, with two
// 8x8 falloff multiplies, is the state loop that sets the clock. Configuration
// writes land at once and must only be made while no request is in flight.
module stereo_bar_meter_peak_hold (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  sbm_pkg::cfg_idx_t             cfg_index,
  input  sbm_pkg::cfg_t                 cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbm_pkg::mag_t                 left_magnitude,
  input  sbm_pkg::mag_t                 right_magnitude,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sbm_pkg::OUT_BITS-1:0]  left_level,
  output logic [sbm_pkg::OUT_BITS-1:0]  right_level,
  output logic [sbm_pkg::OUT_BITS-1:0]  left_peak,
  output logic [sbm_pkg::OUT_BITS-1:0]  right_peak,
  output logic                          left_red,
  output logic                          right_red
);

  // configuration registers
  sbm_pkg::cfg_t   segment_count;
  sbm_pkg::cfg_t   red_threshold;
  sbm_pkg::cfg_t   decay_factor;
  sbm_pkg::timer_t hold_ticks;

  // quantizer stage
  logic            q_valid;
  logic            q_valid_next;
  logic            q_load;
  sbm_pkg::level_t q_left;
  sbm_pkg::level_t q_right;

  // meter state
  sbm_pkg::chan_state_t left_st;
  sbm_pkg::chan_state_t right_st;
  sbm_pkg::chan_state_t left_st_next;
  sbm_pkg::chan_state_t right_st_next;
  sbm_pkg::timer_t      hold_timer;
  sbm_pkg::timer_t      timer_mid;
  sbm_pkg::timer_t      hold_timer_next;

  // output register control
  logic out_load;
  logic out_valid_next;

  // --- configuration ---
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= sbm_pkg::RST_SEGMENT_COUNT;
      red_threshold <= sbm_pkg::RST_RED_THRESHOLD;
      decay_factor  <= sbm_pkg::RST_DECAY_FACTOR;
      hold_ticks    <= sbm_pkg::RST_HOLD_TICKS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sbm_pkg::CFG_SEGMENT_COUNT: segment_count <= cfg_data;
        sbm_pkg::CFG_RED_THRESHOLD: red_threshold <= cfg_data;
        sbm_pkg::CFG_DECAY_FACTOR:  decay_factor  <= cfg_data;
        sbm_pkg::CFG_HOLD_TICKS:    hold_ticks    <= sbm_pkg::HOLD_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // --- flow control ---
  // output register takes a new result when empty or being drained
  assign out_load = q_valid && (!out_valid || out_ready);
  assign in_ready = !q_valid || out_load;
  assign q_load   = in_valid && in_ready;

  always_comb begin
    q_valid_next = q_valid;
    if (q_load) begin
      q_valid_next = 1'b1;
    end else if (out_load) begin
      q_valid_next = 1'b0;
    end

    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      q_valid   <= q_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // --- quantizer lanes ---
  sbm_quant u_quant_left (
    .clk (clk),
    .en  (q_load),
    .mag (left_magnitude),
    .seg (segment_count),
    .q   (q_left)
  );

  sbm_quant u_quant_right (
    .clk (clk),
    .en  (q_load),
    .mag (right_magnitude),
    .seg (segment_count),
    .q   (q_right)
  );

  // --- channel updaters, left feeds the timer into right ---
  sbm_chan u_chan_left (
    .q            (q_left),
    .cur          (left_st),
    .timer_in     (hold_timer),
    .hold_ticks   (hold_ticks),
    .decay_factor (decay_factor),
    .nxt          (left_st_next),
    .timer_out    (timer_mid)
  );

  sbm_chan u_chan_right (
    .q            (q_right),
    .cur          (right_st),
    .timer_in     (timer_mid),
    .hold_ticks   (hold_ticks),
    .decay_factor (decay_factor),
    .nxt          (right_st_next),
    .timer_out    (hold_timer_next)
  );

  // state moves only when a result enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      left_st    <= '0;
      right_st   <= '0;
      hold_timer <= '0;
    end else if (out_load) begin
      left_st    <= left_st_next;
      right_st   <= right_st_next;
      hold_timer <= hold_timer_next;
    end
  end

  // --- output register ---
  always_ff @(posedge clk) begin
    if (out_load) begin
      left_level  <= sbm_pkg::OUT_BITS'(left_st_next.shown);
      right_level <= sbm_pkg::OUT_BITS'(right_st_next.shown);
      left_peak   <= sbm_pkg::OUT_BITS'(left_st_next.peak);
      right_peak  <= sbm_pkg::OUT_BITS'(right_st_next.peak);
      left_red    <= sbm_pkg::WIDE_BITS'(left_st_next.shown) >=
                     sbm_pkg::WIDE_BITS'(red_threshold);
      right_red   <= sbm_pkg::WIDE_BITS'(right_st_next.shown) >=
                     sbm_pkg::WIDE_BITS'(red_threshold);
    end
  end

endmodule

// File: hw/rtl/sbm_checker.sv
// ----------------------------------------------------------------------------
// sbm_checker
// port-level checks of the stereo bar meter, bound to the top level
// ----------------------------------------------------------------------------
`include "stereo_bar_meter_peak_hold_defines.svh"

module sbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_write,
  input sbm_pkg::cfg_idx_t             cfg_index,
  input sbm_pkg::cfg_t                 cfg_data,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sbm_pkg::OUT_BITS-1:0]  left_level,
  input logic [sbm_pkg::OUT_BITS-1:0]  right_level,
  input logic [sbm_pkg::OUT_BITS-1:0]  left_peak,
  input logic [sbm_pkg::OUT_BITS-1:0]  right_peak,
  input logic                          left_red,
  input logic                          right_red
);

  sbm_pkg::cfg_t                  red_shadow;
  logic [2:0]                     pending;
  logic [sbm_pkg::OUT_BITS:0]     prev_left_peak;
  logic [sbm_pkg::OUT_BITS:0]     prev_right_peak;
  logic                           in_fire;
  logic                           out_fire;
  logic                           out_stall;
  logic [4*sbm_pkg::OUT_BITS+1:0] result_bits;
  logic                           red_ok;
  logic                           peak_ok;
  logic                           count_ok;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign result_bits = {left_level, right_level, left_peak, right_peak, left_red, right_red};
  assign red_ok = (left_red == (left_level >= red_shadow)) &&
                  (right_red == (right_level >= red_shadow));
  assign peak_ok = (({1'b0, left_peak} + (sbm_pkg::OUT_BITS+1)'(1)) >= prev_left_peak) &&
                   (({1'b0, right_peak} + (sbm_pkg::OUT_BITS+1)'(1)) >= prev_right_peak);
  assign count_ok = (pending <= 3'd2) && (!out_valid || (pending != 3'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      red_shadow      <= sbm_pkg::RST_RED_THRESHOLD;
      pending         <= '0;
      prev_left_peak  <= '0;
      prev_right_peak <= '0;
    end else begin
      if (cfg_write && (cfg_index == sbm_pkg::CFG_RED_THRESHOLD)) begin
        red_shadow <= cfg_data;
      end
      pending <= pending + 3'(in_fire) - 3'(out_fire);
      if (out_fire) begin
        prev_left_peak  <= {1'b0, left_peak};
        prev_right_peak <= {1'b0, right_peak};
      end
    end
  end

  // held result stays put while stalled
  `SBM_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(result_bits), "stalled result moved")

  // red flags follow the shown level and the written threshold
  `SBM_ASSERT_NOW(a_red_flags, out_valid, red_ok, "red flag mismatch")

  // a held peak falls by at most one segment per request
  `SBM_ASSERT_NOW(a_peak_fall, out_fire, peak_ok, "peak fell too fast")

  // no result without a request in flight, at most two in flight
  `SBM_ASSERT_NOW(a_in_flight, 1'b1, count_ok, "request count out of range")

endmodule

bind stereo_bar_meter_peak_hold sbm_checker u_sbm_checker (.*);
